// ===== src/stramp_pkg.sv =====
`default_nettype none

package stramp_pkg;

    localparam int unsigned TICK_RATE_HZ_DEF = 1000000;
    localparam int unsigned DIV_N_W          = 32;
    localparam int unsigned DIV_D_W          = 16;
    localparam int unsigned RAMP_DIVISOR     = 2000;

    // 2000 = 16 * 125: drop 4 bits, then multiply by ceil(2^35 / 125)
    localparam int unsigned RAMP_PRE_SHIFT   = 4;
    localparam int unsigned RAMP_RECIP_SHIFT = 35;
    localparam int unsigned RAMP_RECIP_W     = 29;
    localparam logic [RAMP_RECIP_W-1:0] RAMP_RECIP = 29'd274877907;

    localparam logic [15:0] SPEED_RST  = 16'd1000;
    localparam logic [15:0] ACCEL_RST  = 16'd100;
    localparam logic [15:0] DIST_RST   = 16'd0;
    localparam logic [15:0] PERIOD_RST = 16'd5000;

    localparam logic [1:0] CFG_SPEED  = 2'd0;
    localparam logic [1:0] CFG_ACCEL  = 2'd1;
    localparam logic [1:0] CFG_DIST   = 2'd2;
    localparam logic [1:0] CFG_PERIOD = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        EV_RUN    = 3'd0,
        EV_DONE   = 3'd1,
        EV_SWITCH = 3'd2,
        EV_REJECT = 3'd3,
        EV_IGNORE = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        DIV_TGT   = 2'd0,
        DIV_DELTA = 2'd1
    } t_div_op;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== src/stepper_trapezoid_ramp.sv =====
// Channel    Dir  Transaction on       Payload
// s_axis     in   tvalid & tready      tuser: opcode; tdata: limit_switch
// m_axis     out  tvalid & tready      tuser: event_code; tdata: period, compare, phase, steps
// cfg        in   we                   idx selects register, data is the value
//
// Tick, ignored or zero-speed start: result passes through S_TICK or S_REPORT into the output
// register once it is free, then the block is ready again. A start runs one or two divisions
// on a shared radix-2 divider (the ramp length comes from a reciprocal multiply meanwhile).
// Reset is synchronous, active low; it restores register and motion defaults.
// A waiting result does not block acceptance; a finished item holds until the
// output register is free.
`default_nettype none

module stepper_trapezoid_ramp #(
    parameter int unsigned TICK_RATE_HZ = stramp_pkg::TICK_RATE_HZ_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [0] limit_switch
    input  wire logic [0:0]  i_s_axis_tuser,   // [0] opcode
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [55:0]      o_m_axis_tdata,   // [15:0] step_period, [30:16] pulse_compare,
                                               // [32:31] move_phase, [48:33] steps_done
    output logic [2:0]       o_m_axis_tuser,   // [2:0] event_code
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    localparam int unsigned NW  = stramp_pkg::DIV_N_W;
    localparam int unsigned PW  = NW - stramp_pkg::RAMP_PRE_SHIFT;
    localparam int unsigned MW  = PW + stramp_pkg::RAMP_RECIP_W;
    localparam int unsigned RQW = MW - stramp_pkg::RAMP_RECIP_SHIFT;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV    = 5'b00010,
        S_COMMIT = 5'b00100,
        S_TICK   = 5'b01000,
        S_REPORT = 5'b10000
    } t_state;

    function automatic logic [2:0] settle(input stramp_pkg::t_phase ph_in,
                                          input logic [15:0] step,
                                          input logic [15:0] ramp,
                                          input logic [15:0] len);
        stramp_pkg::t_phase ph;
        logic               fin;
        ph  = ph_in;
        fin = 1'b0;
        if (ph == stramp_pkg::PH_ACCEL && step == ramp)
            ph = stramp_pkg::PH_CRUISE;
        if (ph == stramp_pkg::PH_CRUISE && step == 16'(len - ramp))
            ph = stramp_pkg::PH_DECEL;
        if (ph == stramp_pkg::PH_DECEL && step == len) begin
            ph  = stramp_pkg::PH_IDLE;
            fin = 1'b1;
        end
        return {fin, ph};
    endfunction

    t_state               r_state, n_state;
    logic                 r_sw, n_sw;
    stramp_pkg::t_event   r_ev, n_ev;
    stramp_pkg::t_div_op  r_div_op, n_div_op;
    logic [NW-1:0]        r_prod, n_prod;
    logic [RQW-1:0]       r_ramp_quo;
    stramp_pkg::t_div_req r_div_req, n_div_req;
    stramp_pkg::t_div_rsp div_rsp;
    logic [15:0]          r_new_tgt, n_new_tgt;
    logic [15:0]          r_new_ramp, n_new_ramp;
    logic [15:0]          r_new_delta, n_new_delta;

    logic [15:0]          r_period, n_period;
    logic [15:0]          r_step, n_step;
    stramp_pkg::t_phase   r_phase, n_phase;
    logic [15:0]          r_tgt, n_tgt;
    logic [15:0]          r_ramp, n_ramp;
    logic [15:0]          r_delta, n_delta;
    logic [15:0]          r_move_len, n_move_len;
    logic [15:0]          r_top, n_top;

    logic [15:0]          r_speed, r_accel, r_dist, r_start;

    logic                 r_out_valid, n_out_valid;
    logic [15:0]          r_out_period, n_out_period;
    logic [15:0]          r_out_step, n_out_step;
    stramp_pkg::t_phase   r_out_phase, n_out_phase;
    stramp_pkg::t_event   r_out_ev, n_out_ev;

    logic                 s_acc;
    logic                 fire;
    logic                 out_load;
    logic [15:0]          t_step;
    logic [16:0]          acc_lim;
    logic [16:0]          dec_sum;
    logic [15:0]          tick_period;
    logic [2:0]           tick_st;
    logic [2:0]           com_st;
    logic [MW-1:0]        ramp_mul;
    logic [15:0]          tgt_sat;
    logic [15:0]          ramp_sat;
    logic [15:0]          delta_sat;

    stramp_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_div_req),
        .o_rsp  (div_rsp)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign fire            = !r_out_valid || i_m_axis_tready;

    assign t_step  = r_step + 16'd1;
    assign acc_lim = {1'b0, r_tgt} + {1'b0, r_delta};
    assign dec_sum = {1'b0, r_period} + {1'b0, r_delta};

    always_comb begin
        tick_period = r_period;
        if (r_phase == stramp_pkg::PH_ACCEL) begin
            tick_period = ({1'b0, r_period} < acc_lim) ? r_tgt : r_period - r_delta;
        end else if (r_phase == stramp_pkg::PH_DECEL) begin
            tick_period = (dec_sum > {1'b0, r_top}) ? r_top : dec_sum[15:0];
        end
    end

    assign tick_st = settle(r_phase, t_step, r_ramp, r_move_len);
    assign com_st  = settle(stramp_pkg::PH_ACCEL, 16'd0, r_new_ramp, r_dist);

    assign ramp_mul = MW'(r_prod[NW-1:stramp_pkg::RAMP_PRE_SHIFT])
                      * MW'(stramp_pkg::RAMP_RECIP);

    assign tgt_sat   = (div_rsp.quotient > {{(NW-16){1'b0}}, r_start})
                       ? r_start : div_rsp.quotient[15:0];
    assign ramp_sat  = (|r_ramp_quo[RQW-1:16]) ? 16'hFFFF : r_ramp_quo[15:0];
    assign delta_sat = ((|div_rsp.quotient[NW-1:16]) || (&div_rsp.quotient[15:0]))
                       ? 16'hFFFF : div_rsp.quotient[15:0] + 16'd1;

    always_comb begin
        n_state     = r_state;
        n_sw        = r_sw;
        n_ev        = r_ev;
        n_div_op    = r_div_op;
        n_prod      = r_prod;
        n_div_req   = r_div_req;
        n_div_req.start = 1'b0;
        n_new_tgt   = r_new_tgt;
        n_new_ramp  = r_new_ramp;
        n_new_delta = r_new_delta;
        n_period    = r_period;
        n_step      = r_step;
        n_phase     = r_phase;
        n_tgt       = r_tgt;
        n_ramp      = r_ramp;
        n_delta     = r_delta;
        n_move_len  = r_move_len;
        n_top       = r_top;
        out_load    = 1'b0;
        n_out_ev    = r_out_ev;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_sw = i_s_axis_tdata[0];
                    if (i_s_axis_tuser[0]) begin
                        if (r_phase == stramp_pkg::PH_IDLE) begin
                            n_ev    = stramp_pkg::EV_IGNORE;
                            n_state = S_REPORT;
                        end else begin
                            n_state = S_TICK;
                        end
                    end else if (r_phase != stramp_pkg::PH_IDLE) begin
                        n_ev    = stramp_pkg::EV_IGNORE;
                        n_state = S_REPORT;
                    end else if (r_speed == 16'd0) begin
                        n_ev    = stramp_pkg::EV_REJECT;
                        n_state = S_REPORT;
                    end else begin
                        n_prod    = NW'(r_speed) * NW'(r_accel);
                        n_div_req = '{start: 1'b1, dividend: NW'(TICK_RATE_HZ),
                                      divisor: r_speed};
                        n_div_op  = stramp_pkg::DIV_TGT;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    case (r_div_op)
                        stramp_pkg::DIV_TGT: begin
                            n_new_tgt  = tgt_sat;
                            n_new_ramp = ramp_sat;
                            if ({1'b0, r_dist} < {ramp_sat, 1'b0}) begin
                                n_ev    = stramp_pkg::EV_REJECT;
                                n_state = S_REPORT;
                            end else if (ramp_sat == 16'd0) begin
                                n_new_delta = 16'd0;
                                n_state     = S_COMMIT;
                            end else begin
                                n_div_req = '{start: 1'b1,
                                              dividend: {{(NW-16){1'b0}}, r_start - tgt_sat},
                                              divisor: ramp_sat};
                                n_div_op  = stramp_pkg::DIV_DELTA;
                            end
                        end
                        default: begin
                            n_new_delta = delta_sat;
                            n_state     = S_COMMIT;
                        end
                    endcase
                end
            end
            S_COMMIT: begin
                if (fire) begin
                    n_tgt      = r_new_tgt;
                    n_ramp     = r_new_ramp;
                    n_delta    = r_new_delta;
                    n_move_len = r_dist;
                    n_top      = r_start;
                    n_period   = r_start;
                    n_step     = 16'd0;
                    if (r_sw) begin
                        n_phase  = stramp_pkg::PH_IDLE;
                        n_out_ev = stramp_pkg::EV_SWITCH;
                    end else begin
                        n_phase  = stramp_pkg::t_phase'(com_st[1:0]);
                        n_out_ev = com_st[2] ? stramp_pkg::EV_DONE : stramp_pkg::EV_RUN;
                    end
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_TICK: begin
                if (fire) begin
                    if (r_sw) begin
                        n_phase  = stramp_pkg::PH_IDLE;
                        n_out_ev = stramp_pkg::EV_SWITCH;
                    end else begin
                        n_step   = t_step;
                        n_period = tick_period;
                        n_phase  = stramp_pkg::t_phase'(tick_st[1:0]);
                        n_out_ev = tick_st[2] ? stramp_pkg::EV_DONE : stramp_pkg::EV_RUN;
                    end
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_REPORT: begin
                if (fire) begin
                    n_out_ev = r_ev;
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_period = r_out_period;
        n_out_step   = r_out_step;
        n_out_phase  = r_out_phase;
        if (out_load) begin
            n_out_valid  = 1'b1;
            n_out_period = n_period;
            n_out_step   = n_step;
            n_out_phase  = n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_req   <= '0;
            r_out_valid <= 1'b0;
            r_period    <= stramp_pkg::PERIOD_RST;
            r_step      <= 16'd0;
            r_phase     <= stramp_pkg::PH_IDLE;
            r_tgt       <= 16'd0;
            r_ramp      <= 16'd0;
            r_delta     <= 16'd0;
            r_move_len  <= 16'd0;
            r_top       <= stramp_pkg::PERIOD_RST;
            r_speed     <= stramp_pkg::SPEED_RST;
            r_accel     <= stramp_pkg::ACCEL_RST;
            r_dist      <= stramp_pkg::DIST_RST;
            r_start     <= stramp_pkg::PERIOD_RST;
        end else begin
            r_state     <= n_state;
            r_div_req   <= n_div_req;
            r_out_valid <= n_out_valid;
            r_period    <= n_period;
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_tgt       <= n_tgt;
            r_ramp      <= n_ramp;
            r_delta     <= n_delta;
            r_move_len  <= n_move_len;
            r_top       <= n_top;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    stramp_pkg::CFG_SPEED:  r_speed <= i_cfg_data;
                    stramp_pkg::CFG_ACCEL:  r_accel <= i_cfg_data;
                    stramp_pkg::CFG_DIST:   r_dist  <= i_cfg_data;
                    stramp_pkg::CFG_PERIOD: r_start <= i_cfg_data;
                    default:                r_start <= r_start;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw         <= n_sw;
        r_ev         <= n_ev;
        r_div_op     <= n_div_op;
        r_prod       <= n_prod;
        r_ramp_quo   <= ramp_mul[MW-1:stramp_pkg::RAMP_RECIP_SHIFT];
        r_new_tgt    <= n_new_tgt;
        r_new_ramp   <= n_new_ramp;
        r_new_delta  <= n_new_delta;
        r_out_period <= n_out_period;
        r_out_step   <= n_out_step;
        r_out_phase  <= n_out_phase;
        r_out_ev     <= n_out_ev;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_step, r_out_phase, r_out_period[15:1], r_out_period};
    assign o_m_axis_tuser  = r_out_ev;

`ifndef NO_ASSERTIONS
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != stramp_pkg::PH_IDLE) |-> (r_step <= r_move_len))
        else $error("step count beyond move length");

    a_period_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != stramp_pkg::PH_IDLE) |-> (r_period >= r_tgt && r_period <= r_top))
        else $error("period outside cruise and start limits");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider result outside division sequence");

    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ev == stramp_pkg::EV_DONE) |-> (r_out_step == r_move_len))
        else $error("finished move reports wrong step count");
`endif

endmodule

`default_nettype wire

// ===== src/stramp_div.sv =====
`default_nettype none

module stramp_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire stramp_pkg::t_div_req i_req,
    output stramp_pkg::t_div_rsp      o_rsp
);

    localparam int unsigned NW   = stramp_pkg::DIV_N_W;
    localparam int unsigned DW   = stramp_pkg::DIV_D_W;
    localparam int unsigned CW   = $clog2(NW);
    localparam logic [CW-1:0] LAST = CW'(NW - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [NW-1:0] r_quo;

    logic [DW:0] rem_sh;
    logic [DW:0] diff;
    logic        ge;

    assign rem_sh = {r_rem, r_quo[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign diff   = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                r_quo <= {r_quo[NW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire
